@@ rtl/core/xbc_pkg.sv @@
// Shared types, constants and round helpers for the XTEA block cipher unit.
// No dependencies; used by xbc_stage, xtea_block_cipher_unit and xbc_checker.
package xbc_pkg;

  localparam int unsigned CycleCount = 32;
  localparam int unsigned HalfRounds = 2 * CycleCount;
  localparam int unsigned StageIdxW  = $clog2(HalfRounds);
  localparam int unsigned WordW      = 32;
  localparam int unsigned KeyWords   = 4;
  localparam int unsigned CfgIdxW    = 8;

  localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_0 = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_1 = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_2 = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_3 = 8'd3;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic             op;
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
  } blk_t;

  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // Round sum seen by half-round h when encrypting: Delta * ceil(h / 2).
  function automatic logic [WordW-1:0] enc_sum(input logic [StageIdxW-1:0] h);
    logic [StageIdxW:0] n;
    n = ({1'b0, h} + (StageIdxW+1)'(1)) >> 1;
    enc_sum = WordW'(Delta * WordW'(n));
  endfunction

  // Decryption walks the sums backward from Delta * CycleCount.
  function automatic logic [WordW-1:0] dec_sum(input logic [StageIdxW-1:0] h);
    logic [StageIdxW:0] n;
    n = ({1'b0, h} + (StageIdxW+1)'(1)) >> 1;
    dec_sum = WordW'(Delta * (WordW'(CycleCount) - WordW'(n)));
  endfunction

endpackage

@@ rtl/core/xbc_stage.sv @@
// One registered XTEA half-round (one Feistel update of v0 or v1).
// Depends on xbc_pkg.
module xbc_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [xbc_pkg::StageIdxW-1:0] stage_i,
  input  xbc_pkg::key_t                 key_i,
  input  logic                          valid_i,
  input  xbc_pkg::blk_t                 blk_i,
  output logic                          valid_o,
  output xbc_pkg::blk_t                 blk_o
);

  logic                       valid_q;
  xbc_pkg::blk_t              blk_q, blk_d;
  logic                       upd_v0;
  logic [xbc_pkg::WordW-1:0]  sum, src, dst, fk, nxt;
  logic [1:0]                 ksel;

  always_comb begin
    // Encrypt updates v0 on even half-rounds, decrypt on odd ones.
    upd_v0 = (blk_i.op == xbc_pkg::OP_ENCRYPT) ^ stage_i[0];
    sum    = (blk_i.op == xbc_pkg::OP_DECRYPT) ? xbc_pkg::dec_sum(stage_i)
                                               : xbc_pkg::enc_sum(stage_i);
    ksel   = upd_v0 ? sum[1:0] : sum[12:11];
    src    = upd_v0 ? blk_i.v1 : blk_i.v0;
    dst    = upd_v0 ? blk_i.v0 : blk_i.v1;
    fk     = xbc_pkg::mix(src) ^ (sum + key_i[ksel]);
    nxt    = (blk_i.op == xbc_pkg::OP_DECRYPT) ? (dst - fk) : (dst + fk);
    blk_d  = blk_i;
    if (upd_v0) begin
      blk_d.v0 = nxt;
    end else begin
      blk_d.v1 = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

@@ rtl/core/xtea_block_cipher_unit.sv @@
// XTEA block cipher unit: 64-bit blocks, 128-bit key, ECB, fully pipelined.
// Depends on xbc_pkg and xbc_stage.
// Path: the first of 64 half-round stages loads a beat at its accepting
// edge and the output register follows the last one; an output stall
// can hold a beat anywhere along the chain.
// Throughput: one beat per cycle while unstalled, set by the 64-stage pipeline.
// Reset: rst_ni clears all valid bits and the four key words to zero.
module xtea_block_cipher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [xbc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [xbc_pkg::WordW-1:0]   cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [xbc_pkg::WordW-1:0]   word_first_i,
  input  logic [xbc_pkg::WordW-1:0]   word_second_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [xbc_pkg::WordW-1:0]   result_first_o,
  output logic [xbc_pkg::WordW-1:0]   result_second_o
);

  localparam int unsigned NStages = xbc_pkg::HalfRounds;

  // Key registers; user must write only while pipeline is idle, not enforced.
  xbc_pkg::key_t key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        xbc_pkg::REG_KEY_WORD_0: key_q[0] <= cfg_data_i;
        xbc_pkg::REG_KEY_WORD_1: key_q[1] <= cfg_data_i;
        xbc_pkg::REG_KEY_WORD_2: key_q[2] <= cfg_data_i;
        xbc_pkg::REG_KEY_WORD_3: key_q[3] <= cfg_data_i;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Stage chain: element k feeds stage k, element k+1 holds its result.
  logic          valid_chain [NStages+1];
  xbc_pkg::blk_t blk_chain   [NStages+1];

  logic          pipe_adv;
  logic          out_load;
  logic          out_valid_q;
  xbc_pkg::blk_t out_blk_q;

  assign valid_chain[0] = in_valid_i;
  assign blk_chain[0]   = '{op: opcode_i, v0: word_first_i, v1: word_second_i};

  for (genvar k = 0; k < NStages; k++) begin : g_stage
    xbc_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (pipe_adv),
      .stage_i (xbc_pkg::StageIdxW'(k)),
      .key_i   (key_q),
      .valid_i (valid_chain[k]),
      .blk_i   (blk_chain[k]),
      .valid_o (valid_chain[k+1]),
      .blk_o   (blk_chain[k+1])
    );
  end

  // The output register takes a beat when it is empty or being drained.
  // The whole chain advances whenever its last stage can move on (or is
  // empty), so a result waiting at the output does not block new beats
  // as long as a bubble sits in the last stage.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign pipe_adv   = !valid_chain[NStages] || out_load;
  assign in_stall_o = !pipe_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= valid_chain[NStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_blk_q <= blk_chain[NStages];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_first_o  = out_blk_q.v0;
  assign result_second_o = out_blk_q.v1;

endmodule

@@ rtl/core/xbc_checker.sv @@
// Port-level checks for xtea_block_cipher_unit, attached by bind.
// Depends on xbc_pkg and the top level's port list.
module xbc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [xbc_pkg::WordW-1:0]   result_first_o,
  input logic [xbc_pkg::WordW-1:0]   result_second_o
);

  // A stalled result beat stays valid.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_first_o) && $stable(result_second_o))
    else $error("result payload changed while stalled");

  // Input back-pressure only comes from a blocked output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind xtea_block_cipher_unit xbc_checker u_xbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_first_o  (result_first_o),
  .result_second_o (result_second_o)
);
